### rtl/core/ftarb_pkg.sv
package ftarb_pkg;

  typedef enum logic [2:0] {
    REG_NUM_LOOPS         = 3'd0,
    REG_CORRECTION_ENABLE = 3'd1,
    REG_RUBBER_SLOPE      = 3'd2,
    REG_RUBBER_OFFSET     = 3'd3,
    REG_LOW_SLOPE         = 3'd4,
    REG_LOW_OFFSET        = 3'd5,
    REG_MIN_VALUE         = 3'd6,
    REG_MAX_VALUE         = 3'd7
  } reg_idx_t;

  localparam int unsigned TARGET_W = 16;
  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned SLOT_W   = 2;
  localparam int unsigned FIX_W    = 32;
  localparam int unsigned FRAC_W   = 16;

  localparam logic [TARGET_W-1:0] MAX_VALUE_RESET = 16'hFFFF;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [TARGET_W-1:0] value;
  } arb_win_t;

  typedef struct packed {
    logic [1:0]          enable;
    logic [FIX_W-1:0]    rubber_offset;
    logic [FIX_W-1:0]    low_offset;
    logic [TARGET_W-1:0] min_value;
    logic [TARGET_W-1:0] max_value;
  } corr_cfg_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [SLOT_W-1:0]   slot;
    logic                rubber_ready;
    logic [FIX_W-1:0]    rubber_prod;
    logic [FIX_W-1:0]    low_q;
  } s2_t;

endpackage

### rtl/core/ftarb_select.sv
module ftarb_select #(
  parameter int MAX_LOOPS = 4
) (
  input  logic [MAX_LOOPS-1:0] cand,
  input  logic [31:0]          prio  [MAX_LOOPS],
  input  logic [15:0]          value [MAX_LOOPS],
  output ftarb_pkg::arb_win_t  win
);
  import ftarb_pkg::*;

  localparam int IDX_W  = $clog2(MAX_LOOPS);
  localparam int LEAVES = 1 << IDX_W;

  logic [PRIO_W-1:0]   node_prio [2*LEAVES];
  logic [TARGET_W-1:0] node_val  [2*LEAVES];
  logic [IDX_W-1:0]    node_idx  [2*LEAVES];

  always_comb begin
    for (int i = 0; i < 2*LEAVES; i++) begin
      node_prio[i] = '0;
      node_val[i]  = '0;
      node_idx[i]  = '0;
    end
    for (int i = 0; i < LEAVES; i++) begin
      node_idx[LEAVES+i] = IDX_W'(i);
    end
    for (int i = 0; i < MAX_LOOPS; i++) begin
      node_prio[LEAVES+i] = cand[i] ? prio[i] : '0;
      node_val[LEAVES+i]  = value[i];
    end
    // The right half wins only when strictly greater, so ties go to the lower slot.
    for (int k = LEAVES-1; k >= 1; k--) begin
      if (node_prio[2*k+1] > node_prio[2*k]) begin
        node_prio[k] = node_prio[2*k+1];
        node_val[k]  = node_val[2*k+1];
        node_idx[k]  = node_idx[2*k+1];
      end else begin
        node_prio[k] = node_prio[2*k];
        node_val[k]  = node_val[2*k];
        node_idx[k]  = node_idx[2*k];
      end
    end
  end

  assign win.found = (node_prio[1] != '0);
  assign win.value = node_val[1];
  assign win.slot  = SLOT_W'(node_idx[1]);

endmodule

### rtl/core/ftarb_correct.sv
module ftarb_correct (
  input  ftarb_pkg::s2_t       stage,
  input  ftarb_pkg::corr_cfg_t cfg,
  output logic [15:0]          drive_value
);
  import ftarb_pkg::*;

  logic signed [FIX_W:0]     rubber_sum;
  logic                      rubber_hit;
  logic [TARGET_W-1:0]       rubber_floor;
  logic [TARGET_W-1:0]       t1;
  logic signed [FIX_W:0]     low_sum;
  logic signed [FIX_W-FRAC_W+1:0] low_m;
  logic                      low_hit;
  logic [TARGET_W:0]         t2;

  always_comb begin
    rubber_sum   = $signed({stage.rubber_prod[FIX_W-1], stage.rubber_prod})
                 + $signed({cfg.rubber_offset[FIX_W-1], cfg.rubber_offset});
    rubber_hit   = cfg.enable[0] && stage.rubber_ready && (rubber_sum > 0);
    rubber_floor = rubber_sum[FIX_W-1:FRAC_W];
    t1 = (rubber_hit && (rubber_floor > stage.target)) ? rubber_floor : stage.target;

    low_sum = $signed({stage.low_q[FIX_W-1], stage.low_q})
            + $signed({cfg.low_offset[FIX_W-1], cfg.low_offset});
    low_m   = $signed({low_sum[FIX_W], low_sum[FIX_W:FRAC_W]})
            + $signed({2'b00, cfg.min_value});
    low_hit = cfg.enable[1] && (low_m > 0) && (low_m > $signed({2'b00, t1}));
    t2      = low_hit ? low_m[TARGET_W:0] : {1'b0, t1};

    if (t2 > {1'b0, cfg.max_value}) begin
      drive_value = cfg.max_value;
    end else begin
      drive_value = t2[TARGET_W-1:0];
    end
  end

endmodule

### rtl/core/fan_target_max_priority_arbiter.sv
// An accepted input moves through the first stage, the second stage and the result register behind out_valid.
// Throughput: one transaction per cycle while out_stall is low; a new one is taken while a result waits.
// The slot compare tree and the two multipliers sit in the first stage, the
// floor arithmetic and clamp in the second, and the result register follows.
// Reset (rst, synchronous, active high) empties the pipeline, clears all pending
// marks and returns the registers to their reset values.
module fan_target_max_priority_arbiter #(
  parameter int MAX_LOOPS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [1:0]  loop_slot,
  input  logic [15:0] requested_target,
  input  logic [31:0] priority_req,
  input  logic        rubber_ready,
  input  logic [15:0] rubber_reference,
  input  logic [31:0] power_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] drive_value,
  output logic [1:0]  winner_slot
);
  import ftarb_pkg::*;

  localparam int CNT_W = $clog2(MAX_LOOPS + 1);

  logic [2:0]          num_loops;
  logic [1:0]          correction_enable;
  logic [FIX_W-1:0]    rubber_slope;
  logic [FIX_W-1:0]    rubber_offset;
  logic signed [FIX_W-1:0] low_slope;
  logic [FIX_W-1:0]    low_offset;
  logic [TARGET_W-1:0] min_value;
  logic [TARGET_W-1:0] max_value;

  logic [MAX_LOOPS-1:0] pending;
  logic [MAX_LOOPS-1:0] pending_next;
  logic [TARGET_W-1:0]  req_value [MAX_LOOPS];
  logic [PRIO_W-1:0]    req_prio  [MAX_LOOPS];

  logic                    s1_valid;
  logic                    s1_opcode;
  logic [SLOT_W-1:0]       s1_slot;
  logic [TARGET_W-1:0]     s1_target;
  logic [PRIO_W-1:0]       s1_prio;
  logic                    s1_rubber_ready;
  logic [TARGET_W-1:0]     s1_rubber_reference;
  logic signed [FIX_W-1:0] s1_power_sample;

  logic          s2_valid;
  s2_t           s2;
  s2_t           s2_next;
  corr_cfg_t     cfg;
  logic [15:0]   drive_next;

  logic                 accept;
  logic                 s1_move;
  logic                 s2_move;
  logic [CNT_W-1:0]     n_eff;
  logic                 bypass;
  logic                 slot_write;
  logic [MAX_LOOPS-1:0] eff_pending;
  logic [MAX_LOOPS-1:0] cand;
  logic [TARGET_W-1:0]  eff_value [MAX_LOOPS];
  logic [PRIO_W-1:0]    eff_prio  [MAX_LOOPS];
  logic                 all_pending;
  arb_win_t             win;
  logic                 arb_win;
  logic                 s1_emit;
  logic signed [63:0]   low_prod;

  assign accept   = in_valid && !in_stall;
  assign s2_move  = s2_valid && (!out_valid || !out_stall);
  assign s1_move  = s1_valid && (!s2_valid || s2_move);
  assign in_stall = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_loops         <= '0;
      correction_enable <= '0;
      rubber_slope      <= '0;
      rubber_offset     <= '0;
      low_slope         <= '0;
      low_offset        <= '0;
      min_value         <= '0;
      max_value         <= MAX_VALUE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NUM_LOOPS:         num_loops         <= cfg_data[2:0];
        REG_CORRECTION_ENABLE: correction_enable <= cfg_data[1:0];
        REG_RUBBER_SLOPE:      rubber_slope      <= cfg_data;
        REG_RUBBER_OFFSET:     rubber_offset     <= cfg_data;
        REG_LOW_SLOPE:         low_slope         <= $signed(cfg_data);
        REG_LOW_OFFSET:        low_offset        <= cfg_data;
        REG_MIN_VALUE:         min_value         <= cfg_data[15:0];
        REG_MAX_VALUE:         max_value         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_eff = (num_loops > MAX_LOOPS) ? CNT_W'(MAX_LOOPS) : CNT_W'(num_loops);
    bypass = s1_opcode || (n_eff == CNT_W'(1));
    slot_write = !bypass && (n_eff != '0) && (int'(s1_slot) < int'(n_eff));
    all_pending = 1'b1;
    for (int i = 0; i < MAX_LOOPS; i++) begin
      if (slot_write && (i == int'(s1_slot))) begin
        eff_pending[i] = 1'b1;
        eff_value[i]   = s1_target;
        eff_prio[i]    = s1_prio;
      end else begin
        eff_pending[i] = pending[i];
        eff_value[i]   = req_value[i];
        eff_prio[i]    = req_prio[i];
      end
      cand[i] = eff_pending[i] && (i < int'(n_eff));
      if ((i < int'(n_eff)) && !eff_pending[i]) begin
        all_pending = 1'b0;
      end
    end
  end

  ftarb_select #(
    .MAX_LOOPS(MAX_LOOPS)
  ) u_select (
    .cand  (cand),
    .prio  (eff_prio),
    .value (eff_value),
    .win   (win)
  );

  assign arb_win = !bypass && (n_eff != '0) && win.found && all_pending;
  assign s1_emit = bypass || arb_win;
  assign low_prod = s1_power_sample * low_slope;

  always_comb begin
    s2_next.target       = bypass ? s1_target : win.value;
    s2_next.slot         = bypass ? s1_slot : win.slot;
    s2_next.rubber_ready = s1_rubber_ready;
    s2_next.rubber_prod  = {16'd0, s1_rubber_reference} * rubber_slope;
    s2_next.low_q        = low_prod[FIX_W+FRAC_W-1:FRAC_W];
    pending_next = pending;
    if (arb_win) begin
      pending_next = '0;
    end else if (slot_write) begin
      pending_next = eff_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (s1_move) begin
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && slot_write) begin
      for (int i = 0; i < MAX_LOOPS; i++) begin
        if (i == int'(s1_slot)) begin
          req_value[i] <= s1_target;
          req_prio[i]  <= s1_prio;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_opcode           <= opcode;
      s1_slot             <= loop_slot;
      s1_target           <= requested_target;
      s1_prio             <= priority_req;
      s1_rubber_ready     <= rubber_ready;
      s1_rubber_reference <= rubber_reference;
      s1_power_sample     <= $signed(power_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move && s1_emit) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_emit) begin
      s2 <= s2_next;
    end
  end

  assign cfg.enable        = correction_enable;
  assign cfg.rubber_offset = rubber_offset;
  assign cfg.low_offset    = low_offset;
  assign cfg.min_value     = min_value;
  assign cfg.max_value     = max_value;

  ftarb_correct u_correct (
    .stage       (s2),
    .cfg         (cfg),
    .drive_value (drive_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      drive_value <= drive_next;
      winner_slot <= s2.slot;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("Input stalled with an empty first stage.");

  a_win_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_move && arb_win) |=> (pending == '0))
    else $error("Pending marks survived a completed arbitration.");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_move) |=> (s2_valid && $stable(s2)))
    else $error("Second stage lost or changed a blocked transaction.");

  a_no_emit_no_s2: assert property (@(posedge clk) disable iff (rst)
    (s1_move && !s1_emit && !s2_valid) |=> !s2_valid)
    else $error("A transaction with no result reached the second stage.");

endmodule

### test/tb_fan_target_max_priority_arbiter.sv
`timescale 1ns / 1ps

module tb_fan_target_max_priority_arbiter;
  import ftarb_pkg::*;

  localparam int MAX_LOOPS    = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 230;
  localparam logic [1:0] CORR_RUBBER = 2'b01;
  localparam logic [1:0] CORR_LOW    = 2'b10;

  typedef enum logic {OP_LOOP_REQ = 1'b0, OP_DIRECT_SET = 1'b1} fan_op_t;

  typedef struct {
    fan_op_t              op;
    logic [SLOT_W-1:0]    slot;
    logic [TARGET_W-1:0]  target;
    logic [PRIO_W-1:0]    prio;
    logic                 rubber_ready;
    logic [TARGET_W-1:0]  rubber_ref;
    logic signed [FIX_W-1:0] power;
  } fan_request_t;

  typedef struct {
    logic [TARGET_W-1:0] drive;
    logic [SLOT_W-1:0]   slot;
  } fan_drive_t;

  typedef struct {
    logic [2:0]          num_loops;
    logic [1:0]          corr_en;
    logic [FIX_W-1:0]    rubber_slope;
    logic [FIX_W-1:0]    rubber_offset;
    logic [FIX_W-1:0]    low_slope;
    logic [FIX_W-1:0]    low_offset;
    logic [TARGET_W-1:0] min_value;
    logic [TARGET_W-1:0] max_value;
  } fan_settings_t;

  class drive_scoreboard;
    logic [2:0]              num_loops;
    logic [1:0]              corr_en;
    logic signed [FIX_W-1:0] rubber_slope;
    logic signed [FIX_W-1:0] rubber_offset;
    logic signed [FIX_W-1:0] low_slope;
    logic signed [FIX_W-1:0] low_offset;
    logic [TARGET_W-1:0]     min_value;
    logic [TARGET_W-1:0]     max_value;
    bit                      pending [MAX_LOOPS];
    logic [TARGET_W-1:0]     req_value [MAX_LOOPS];
    logic [PRIO_W-1:0]       req_prio [MAX_LOOPS];
    fan_drive_t              expected_q [$];
    int unsigned             mismatches;
    int unsigned             results_checked;

    function new();
      num_loops = '0;
      corr_en = '0;
      rubber_slope = '0;
      rubber_offset = '0;
      low_slope = '0;
      low_offset = '0;
      min_value = '0;
      max_value = MAX_VALUE_RESET;
      foreach (pending[i]) begin
        pending[i] = 1'b0;
        req_value[i] = '0;
        req_prio[i] = '0;
      end
      mismatches = 0;
      results_checked = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] data);
      case (idx)
        REG_NUM_LOOPS:         num_loops = data[2:0];
        REG_CORRECTION_ENABLE: corr_en = data[1:0];
        REG_RUBBER_SLOPE:      rubber_slope = data;
        REG_RUBBER_OFFSET:     rubber_offset = data;
        REG_LOW_SLOPE:         low_slope = data;
        REG_LOW_OFFSET:        low_offset = data;
        REG_MIN_VALUE:         min_value = data[TARGET_W-1:0];
        REG_MAX_VALUE:         max_value = data[TARGET_W-1:0];
        default: ;
      endcase
    endfunction

    // The rubber-band floor keeps the low 32 bits of its product; the low floor
    // keeps the low 32 bits of the product after the fractional shift.
    function logic [TARGET_W-1:0] corrected_target(logic [TARGET_W-1:0] base,
                                                   fan_request_t r);
      longint t, s, prod, q, m;
      logic [FIX_W-1:0] p32;
      t = longint'(base);
      if (corr_en[0] && r.rubber_ready) begin
        p32 = r.rubber_ref * rubber_slope;
        s = longint'($signed(p32)) + longint'(rubber_offset);
        if (s > 0 && (s >>> FRAC_W) > t) t = s >>> FRAC_W;
      end
      if (corr_en[1]) begin
        prod = longint'(r.power) * longint'(low_slope);
        p32 = prod[FIX_W+FRAC_W-1:FRAC_W];
        q = longint'($signed(p32));
        m = ((q + longint'(low_offset)) >>> FRAC_W) + longint'(min_value);
        if (m > 0 && m > t) t = m;
      end
      if (t > longint'(max_value)) t = longint'(max_value);
      return t[TARGET_W-1:0];
    endfunction

    function void note_request(fan_request_t r);
      int unsigned n, best_slot;
      bit all_pending, found;
      logic [PRIO_W-1:0] best_prio;
      logic [TARGET_W-1:0] best_value;
      fan_drive_t res;
      n = (num_loops > MAX_LOOPS) ? MAX_LOOPS : num_loops;
      if (r.op == OP_DIRECT_SET || n == 1) begin
        res.drive = corrected_target(r.target, r);
        res.slot = r.slot;
        expected_q.push_back(res);
        return;
      end
      if (n == 0) return;
      all_pending = 1'b1;
      found = 1'b0;
      best_prio = '0;
      best_value = '0;
      best_slot = 0;
      for (int i = 0; i < n; i++) begin
        if (i == r.slot) begin
          pending[i] = 1'b1;
          req_value[i] = r.target;
          req_prio[i] = r.prio;
        end
        if (!pending[i]) begin
          all_pending = 1'b0;
        end else if (req_prio[i] > best_prio) begin
          best_prio = req_prio[i];
          best_value = req_value[i];
          best_slot = i;
          found = 1'b1;
        end
      end
      if (found && all_pending) begin
        foreach (pending[i]) pending[i] = 1'b0;
        res.drive = corrected_target(best_value, r);
        res.slot = SLOT_W'(best_slot);
        expected_q.push_back(res);
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d at %0t: %s", mismatches, $time, msg);
    endfunction

    function void check_result(logic [TARGET_W-1:0] drive, logic [SLOT_W-1:0] slot);
      fan_drive_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected transaction drive_value=%0d winner_slot=%0d", drive, slot));
        return;
      end
      want = expected_q.pop_front();
      if (drive !== want.drive)
        flag($sformatf("drive_value expected %0d got %0d", want.drive, drive));
      if (slot !== want.slot)
        flag($sformatf("winner_slot expected %0d got %0d", want.slot, slot));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        opcode;
  logic [1:0]  loop_slot;
  logic [15:0] requested_target;
  logic [31:0] priority_req;
  logic        rubber_ready;
  logic [15:0] rubber_reference;
  logic [31:0] power_sample;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] drive_value;
  logic [1:0]  winner_slot;

  logic        hold_rx = 1'b0;
  int unsigned rx_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned phases_run = 0;
  int unsigned reg_writes = 0;
  logic [3:0]  round_sent = '0;
  drive_scoreboard sb;

  fan_target_max_priority_arbiter #(.MAX_LOOPS(MAX_LOOPS)) uut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= hold_rx || (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(drive_value, winner_slot);
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_register(idx, data);
    reg_writes++;
  endtask

  task automatic load_settings(fan_settings_t c);
    write_reg(REG_NUM_LOOPS, 32'(c.num_loops));
    write_reg(REG_CORRECTION_ENABLE, 32'(c.corr_en));
    write_reg(REG_RUBBER_SLOPE, c.rubber_slope);
    write_reg(REG_RUBBER_OFFSET, c.rubber_offset);
    write_reg(REG_LOW_SLOPE, c.low_slope);
    write_reg(REG_LOW_OFFSET, c.low_offset);
    write_reg(REG_MIN_VALUE, 32'(c.min_value));
    write_reg(REG_MAX_VALUE, 32'(c.max_value));
    cfg_write <= 1'b0;
  endtask

  task automatic send_request(fan_request_t r);
    in_valid <= 1'b1;
    opcode <= r.op;
    loop_slot <= r.slot;
    requested_target <= r.target;
    priority_req <= r.prio;
    rubber_ready <= r.rubber_ready;
    rubber_reference <= r.rubber_ref;
    power_sample <= r.power;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
    items_sent++;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic hold_receiver();
    repeat (20) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  endtask

  function automatic fan_request_t make_request(fan_op_t op, int unsigned slot,
                                                logic [15:0] target, logic [31:0] prio,
                                                logic ready, logic [15:0] ref_value,
                                                logic [31:0] power);
    fan_request_t r;
    r.op = op;
    r.slot = SLOT_W'(slot);
    r.target = target;
    r.prio = prio;
    r.rubber_ready = ready;
    r.rubber_ref = ref_value;
    r.power = power;
    return r;
  endfunction

  // Most loop requests complete a round over the registered slots in random
  // order; the rest are direct sets and requests from arbitrary slots.
  function automatic fan_request_t random_request(logic [2:0] loops);
    fan_request_t r;
    int unsigned n, pick;
    n = (loops > MAX_LOOPS) ? MAX_LOOPS : loops;
    r.op = ($urandom_range(0, 99) < 8) ? OP_DIRECT_SET : OP_LOOP_REQ;
    r.slot = SLOT_W'($urandom_range(0, 3));
    if (r.op == OP_LOOP_REQ && n >= 2 && $urandom_range(0, 99) < 85) begin
      if (round_sent == 4'((1 << n) - 1)) round_sent = '0;
      do pick = $urandom_range(0, n - 1); while (round_sent[pick]);
      round_sent[pick] = 1'b1;
      r.slot = SLOT_W'(pick);
    end
    case ($urandom_range(0, 9))
      0: r.prio = '0;
      1: r.prio = '1;
      2, 3: r.prio = $urandom_range(0, 3);
      default: r.prio = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0: r.target = '0;
      1: r.target = '1;
      default: r.target = $urandom_range(0, 16'hFFFF);
    endcase
    r.rubber_ready = ($urandom_range(0, 3) != 0);
    r.rubber_ref = $urandom_range(0, 16'hFFFF);
    if ($urandom_range(0, 9) < 7) begin
      r.power = $urandom_range(0, 32'h00FF_FFFF);
      if ($urandom_range(0, 3) == 0) r.power = -r.power;
    end else begin
      r.power = $urandom;
    end
    return r;
  endfunction

  function automatic fan_settings_t moderate_settings(logic [2:0] loops, logic [1:0] en);
    fan_settings_t c;
    c.num_loops = loops;
    c.corr_en = en;
    c.rubber_slope = $urandom_range(0, 32'h0003_0000);
    if ($urandom_range(0, 3) == 0) c.rubber_slope = -c.rubber_slope;
    c.rubber_offset = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    c.low_slope = $urandom_range(0, 32'h0100_0000);
    c.low_offset = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    c.min_value = $urandom_range(0, 16'h4000);
    c.max_value = $urandom_range(16'h8000, 16'hFFFF);
    return c;
  endfunction

  task automatic run_phase(fan_settings_t c, int unsigned mode, int unsigned count,
                           bit with_hold);
    int unsigned tx_pct;
    tx_pct = (mode == 1) ? 58 : (mode == 3) ? 31 : 0;
    load_settings(c);
    round_sent = '0;
    rx_stall_pct <= (mode == 2) ? 58 : (mode == 3) ? 31 : 0;
    fork
      begin
        for (int k = 0; k < count; k++) begin
          if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
          end
          send_request(random_request(c.num_loops));
        end
      end
      if (with_hold) hold_receiver();
    join
    drain_pipeline();
    phases_run++;
  endtask

  initial begin
    fan_settings_t c;
    sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_NUM_LOOPS;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = OP_LOOP_REQ;
    loop_slot = '0;
    requested_target = '0;
    priority_req = '0;
    rubber_ready = 1'b0;
    rubber_reference = '0;
    power_sample = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: no registered loops, so only direct sets give a result.
    send_request(make_request(OP_LOOP_REQ, 0, 16'd100, 32'd5, 1'b0, '0, '0));
    send_request(make_request(OP_DIRECT_SET, 3, 16'hFFFF, '0, 1'b1, 16'hFFFF, '1));
    send_request(make_request(OP_DIRECT_SET, 0, 16'h0000, '1, 1'b0, '0, '0));
    drain_pipeline();

    c = '{3'd1, 2'b00, '0, '0, '0, '0, '0, 16'hFFFF};
    load_settings(c);
    send_request(make_request(OP_LOOP_REQ, 2, 16'h1234, '0, 1'b0, '0, '0));
    drain_pipeline();

    c = '{3'd4, CORR_RUBBER | CORR_LOW, 32'h0001_0000, '0, 32'h0001_0000, '0, '0, 16'hF000};
    load_settings(c);
    send_request(make_request(OP_LOOP_REQ, 0, 16'd10, 32'd5, 1'b0, '0, '0));
    send_request(make_request(OP_LOOP_REQ, 3, 16'd40, 32'd1, 1'b0, '0, '0));
    send_request(make_request(OP_LOOP_REQ, 1, 16'd20, 32'd9, 1'b0, '0, '0));
    send_request(make_request(OP_LOOP_REQ, 2, 16'd30, 32'd9, 1'b1, 16'd500, '0));
    for (int s = 0; s < MAX_LOOPS; s++)
      send_request(make_request(OP_LOOP_REQ, s, 16'd50, '0, 1'b0, '0, '0));
    send_request(make_request(OP_LOOP_REQ, 2, 16'hFFFF, '1, 1'b0, '0, 32'h7FFF_FFFF));
    send_request(make_request(OP_DIRECT_SET, 1, '0, '0, 1'b1, 16'hFFFF, 32'h8000_0000));
    send_request(make_request(OP_LOOP_REQ, 3, 16'd7, 32'd1, 1'b1, 16'd3, '0));
    drain_pipeline();

    c = '{3'd2, CORR_LOW, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
          16'hFFFF, 16'hFFFF};
    load_settings(c);
    send_request(make_request(OP_LOOP_REQ, 3, 16'd9, 32'd50, 1'b1, '1, '0));
    send_request(make_request(OP_LOOP_REQ, 1, 16'd5, 32'd3, 1'b1, '1, 32'h8000_0000));
    send_request(make_request(OP_LOOP_REQ, 0, 16'd6, 32'd3, 1'b0, '0, 32'h0001_0000));
    drain_pipeline();

    c = '{3'd7, CORR_RUBBER | CORR_LOW, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h8000_0000, '0, '0};
    load_settings(c);
    send_request(make_request(OP_LOOP_REQ, 3, 16'hAAAA, 32'd7, 1'b1, 16'h5555, '1));
    send_request(make_request(OP_LOOP_REQ, 0, 16'h5555, 32'd7, 1'b1, 16'hAAAA, '0));
    send_request(make_request(OP_LOOP_REQ, 1, 16'hFFFF, 32'd2, 1'b0, '0, '0));
    send_request(make_request(OP_LOOP_REQ, 2, 16'h0001, 32'd7, 1'b1, '1, 32'h8000_0000));
    drain_pipeline();
    phases_run++;

    for (int k = 0; k < 8; k++) begin
      case (k)
        0: c = moderate_settings(3'd4, CORR_RUBBER | CORR_LOW);
        1: c = moderate_settings(3'd2, CORR_RUBBER);
        2: c = moderate_settings(3'd3, CORR_LOW);
        3: begin
          c.num_loops = $urandom_range(2, 4);
          c.corr_en = $urandom_range(0, 3);
          c.rubber_slope = $urandom;
          c.rubber_offset = $urandom;
          c.low_slope = $urandom;
          c.low_offset = $urandom;
          c.min_value = $urandom_range(0, 16'hFFFF);
          c.max_value = $urandom_range(0, 16'hFFFF);
        end
        4: c = '{3'd7, CORR_RUBBER | CORR_LOW, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0000, 16'hFFFF, 16'hFFFF};
        5: c = moderate_settings(3'd1, CORR_RUBBER | CORR_LOW);
        6: begin
          c = moderate_settings(3'd4, 2'b00);
          c.max_value = $urandom_range(0, 16'hFFFF);
        end
        default: begin
          c = moderate_settings(3'd2, CORR_RUBBER | CORR_LOW);
          c.rubber_slope = 32'h8000_0000;
          c.rubber_offset = 32'h7FFF_FFFF;
          c.min_value = '0;
          c.max_value = 16'h8000;
        end
      endcase
      run_phase(c, k % 4, PHASE_ITEMS, k == 0 || k == 4);
    end

    $display("Checked %0d drive transactions from %0d requests in %0d phases, %0d register writes.",
             sb.results_checked, items_sent, phases_run, reg_writes);
    $display("Covered ties, zero priorities, stale slots, bypass and floor corrections under stalls.");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### fan_target_max_priority_arbiter.f
rtl/core/ftarb_pkg.sv
rtl/core/ftarb_select.sv
rtl/core/ftarb_correct.sv
rtl/core/fan_target_max_priority_arbiter.sv
test/tb_fan_target_max_priority_arbiter.sv
